### src/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants for the single-wire register link master
// Command and status codes, frame constants, CRC-8 helpers and the burst
// descriptor passed from the controller to the result sequencer.
// ----------------------------------------------------------------------------
package swrl_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READ  = 2'd1,
		PH_WRITE = 2'd2
	} phase_t;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_RX      = 2'd2;
	localparam logic [1:0] CMD_TIMEOUT = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_ECHO     = 3'd1;
	localparam logic [2:0] ST_BAD_ECHO    = 3'd2;
	localparam logic [2:0] ST_NO_REPLY    = 3'd3;
	localparam logic [2:0] ST_SHORT_REPLY = 3'd4;
	localparam logic [2:0] ST_BAD_FRAME   = 3'd5;
	localparam logic [2:0] ST_BAD_CRC     = 3'd6;

	localparam logic [7:0] SYNC_BYTE   = 8'h05;
	localparam logic [7:0] REPLY_NODE  = 8'hFF;
	localparam logic [7:0] WRITE_FLAG  = 8'h80;
	localparam logic [7:0] CRC_POLY    = 8'h07;

	localparam logic [3:0] READ_FRAME_LEN  = 4'd4;
	localparam logic [3:0] WRITE_FRAME_LEN = 4'd8;
	localparam logic [3:0] READ_DONE_COUNT = 4'd12;

	localparam logic [2:0] LAST_IDX_READ  = 3'd3;
	localparam logic [2:0] LAST_IDX_WRITE = 3'd7;
	localparam logic [2:0] LAST_IDX_DONE  = 3'd0;

	localparam int unsigned APB_ADDR_W = 3;
	localparam logic        REG_LINK_ENABLED = 1'b0;

	// one byte into the CRC, LSB first
	function automatic logic [7:0] crc8_feed(logic [7:0] c, logic [7:0] b);
		logic [7:0] r;
		r = c;
		for (int j = 0; j < 8; j++) begin
			if (r[7] ^ b[j]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	// contribution of each message bit to the CRC of a seven-byte message
	function automatic logic [55:0][7:0] crc_contrib_build();
		logic [55:0][7:0] tab;
		logic [6:0][7:0]  msg;
		logic [7:0]       c;
		for (int k = 0; k < 56; k++) begin
			msg = '0;
			msg[k >> 3][k & 7] = 1'b1;
			c = 8'h00;
			for (int b = 0; b < 7; b++) begin
				c = crc8_feed(c, msg[b]);
			end
			tab[k] = c;
		end
		return tab;
	endfunction

	localparam logic [55:0][7:0] CRC_CONTRIB = crc_contrib_build();

	// msg[0] is fed first; leading zero bytes leave a zero CRC unchanged
	function automatic logic [7:0] crc8_frame(logic [6:0][7:0] msg);
		logic [55:0] bits;
		logic [7:0]  c;
		bits = msg;
		c = 8'h00;
		for (int k = 0; k < 56; k++) begin
			if (bits[k]) begin
				c = c ^ CRC_CONTRIB[k];
			end
		end
		return c;
	endfunction

	typedef struct packed {
		logic            tx;
		logic [7:0][7:0] frame;
		logic [2:0]      last_idx;
		logic [2:0]      status;
		logic [31:0]     value;
		logic [3:0]      nrx;
		logic [31:0]     wtot;
		logic [31:0]     eftot;
	} burst_t;

	typedef struct packed {
		logic   load;
		burst_t burst;
	} burst_load_t;

endpackage

### src/swrl_req_if.sv
// ----------------------------------------------------------------------------
// swrl_req_if: command channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface swrl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  node_addr;
	logic [6:0]  reg_addr;
	logic [31:0] write_value;
	logic [7:0]  rx_byte;

	modport source (
		output valid, cmd, node_addr, reg_addr, write_value, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, cmd, node_addr, reg_addr, write_value, rx_byte,
		output ready
	);
endinterface

### src/swrl_rsp_if.sv
// ----------------------------------------------------------------------------
// swrl_rsp_if: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface swrl_rsp_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        done_res;
	logic [2:0]  status;
	logic [31:0] read_value;
	logic [3:0]  bytes_received;
	logic [31:0] write_total;
	logic [31:0] echo_fault_total;
	logic        last;

	modport source (
		output valid, tx_valid, tx_byte, done_res, status, read_value,
		       bytes_received, write_total, echo_fault_total, last,
		input  ready
	);
	modport sink (
		input  valid, tx_valid, tx_byte, done_res, status, read_value,
		       bytes_received, write_total, echo_fault_total, last,
		output ready
	);
endinterface

### src/swrl_apb.sv
// ----------------------------------------------------------------------------
// swrl_apb: configuration register port
// APB-style access to the link enable register.
// ----------------------------------------------------------------------------
module swrl_apb
	import swrl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic                  link_enabled
);

	logic link_enabled_q;
	logic reg_idx;

	assign reg_idx = paddr[APB_ADDR_W-1];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_enabled_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_LINK_ENABLED) begin
			link_enabled_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_LINK_ENABLED) begin
			prdata = {31'd0, link_enabled_q};
		end
	end

	assign link_enabled = link_enabled_q;

endmodule

### src/swrl_ctrl.sv
// ----------------------------------------------------------------------------
// swrl_ctrl: transaction controller
// Holds the link state, builds request frames, checks echo and reply bytes,
// and hands the sequencer a burst descriptor per start and per completion.
// ----------------------------------------------------------------------------
module swrl_ctrl
	import swrl_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	swrl_req_if.sink      request,
	input  logic          slot_free,
	input  logic          link_enabled,
	output burst_load_t   burst_ld
);

	phase_t          phase_q, phase_d;
	logic [3:0]      rx_count_q, rx_count_d;
	logic [7:0][7:0] sent_frame_q, sent_frame_d;
	logic            echo_mismatch_q, echo_mismatch_d;
	logic            reply_bad_frame_q, reply_bad_frame_d;
	logic [7:0]      reply_crc_q, reply_crc_d;
	logic [31:0]     reply_value_q, reply_value_d;
	logic [6:0]      saved_register_q, saved_register_d;
	logic [31:0]     write_count_q, write_count_d;
	logic [31:0]     echo_fault_count_q, echo_fault_count_d;

	logic            acc;
	logic            fin_read, fin_write, crc_ok;
	logic [7:0]      rx;
	logic [7:0]      reg_byte;
	logic [2:0]      st;
	logic [31:0]     val;

	assign request.ready = slot_free;
	assign acc           = request.valid && slot_free;
	assign rx            = request.rx_byte;
	assign reg_byte      = {1'b0, request.reg_addr};

	always_comb begin
		phase_d            = phase_q;
		rx_count_d         = rx_count_q;
		sent_frame_d       = sent_frame_q;
		echo_mismatch_d    = echo_mismatch_q;
		reply_bad_frame_d  = reply_bad_frame_q;
		reply_crc_d        = reply_crc_q;
		reply_value_d      = reply_value_q;
		saved_register_d   = saved_register_q;
		write_count_d      = write_count_q;
		echo_fault_count_d = echo_fault_count_q;
		fin_read           = 1'b0;
		fin_write          = 1'b0;
		crc_ok             = 1'b0;
		st                 = ST_OK;
		val                = '0;
		burst_ld           = '0;
		burst_ld.burst.wtot  = write_count_q;
		burst_ld.burst.eftot = echo_fault_count_q;

		if (acc) begin
			case (request.cmd)
				CMD_READ, CMD_WRITE: begin
					if (!link_enabled) begin
						phase_d                 = PH_IDLE;
						burst_ld.load           = 1'b1;
						burst_ld.burst.status   = ST_NO_ECHO;
						burst_ld.burst.last_idx = LAST_IDX_DONE;
					end else begin
						sent_frame_d[0] = SYNC_BYTE;
						sent_frame_d[1] = request.node_addr;
						if (request.cmd == CMD_READ) begin
							sent_frame_d[2] = reg_byte;
							sent_frame_d[3] = crc8_frame({reg_byte, request.node_addr,
								SYNC_BYTE, 32'd0});
							phase_d = PH_READ;
							burst_ld.burst.last_idx = LAST_IDX_READ;
						end else begin
							sent_frame_d[2] = reg_byte | WRITE_FLAG;
							sent_frame_d[3] = request.write_value[31:24];
							sent_frame_d[4] = request.write_value[23:16];
							sent_frame_d[5] = request.write_value[15:8];
							sent_frame_d[6] = request.write_value[7:0];
							sent_frame_d[7] = crc8_frame({request.write_value[7:0],
								request.write_value[15:8], request.write_value[23:16],
								request.write_value[31:24], reg_byte | WRITE_FLAG,
								request.node_addr, SYNC_BYTE});
							phase_d = PH_WRITE;
							burst_ld.burst.last_idx = LAST_IDX_WRITE;
						end
						rx_count_d        = '0;
						echo_mismatch_d   = 1'b0;
						reply_bad_frame_d = 1'b0;
						reply_crc_d       = '0;
						reply_value_d     = '0;
						saved_register_d  = request.reg_addr;
						burst_ld.load     = 1'b1;
						burst_ld.burst.tx = 1'b1;
						burst_ld.burst.frame = sent_frame_d;
					end
				end
				CMD_TIMEOUT: begin
					case (phase_q)
						PH_READ:  fin_read  = 1'b1;
						PH_WRITE: fin_write = 1'b1;
						default: ;
					endcase
				end
				default: begin
					case (phase_q)
						PH_WRITE: begin
							if (rx != sent_frame_q[rx_count_q[2:0]]) begin
								echo_mismatch_d = 1'b1;
							end
							rx_count_d = rx_count_q + 4'd1;
							if (rx_count_d >= WRITE_FRAME_LEN) begin
								fin_write = 1'b1;
							end
						end
						PH_READ: begin
							case (rx_count_q) inside
								4'd0, 4'd1, 4'd2, 4'd3: begin
									if (rx != sent_frame_q[rx_count_q[2:0]]) begin
										echo_mismatch_d = 1'b1;
									end
								end
								4'd4: begin
									if (rx != SYNC_BYTE) reply_bad_frame_d = 1'b1;
									reply_crc_d = crc8_feed(reply_crc_q, rx);
								end
								4'd5: begin
									if (rx != REPLY_NODE) reply_bad_frame_d = 1'b1;
									reply_crc_d = crc8_feed(reply_crc_q, rx);
								end
								4'd6: begin
									if (rx != {1'b0, saved_register_q}) reply_bad_frame_d = 1'b1;
									reply_crc_d = crc8_feed(reply_crc_q, rx);
								end
								[4'd7:4'd10]: begin
									reply_value_d = {reply_value_q[23:0], rx};
									reply_crc_d   = crc8_feed(reply_crc_q, rx);
								end
								default: ;
							endcase
							if (rx_count_q == 4'd11) begin
								rx_count_d = READ_DONE_COUNT;
								fin_read   = 1'b1;
								crc_ok     = (rx == reply_crc_q);
							end else begin
								rx_count_d = rx_count_q + 4'd1;
								if (rx_count_d >= READ_DONE_COUNT) begin
									fin_read = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			endcase
		end

		if (fin_read) begin
			if (rx_count_d == 4'd0) begin
				st = ST_NO_ECHO;
			end else if (rx_count_d < READ_FRAME_LEN || echo_mismatch_d) begin
				st = ST_BAD_ECHO;
			end else if (rx_count_d == READ_FRAME_LEN) begin
				st = ST_NO_REPLY;
			end else if (rx_count_d < READ_DONE_COUNT) begin
				st = ST_SHORT_REPLY;
			end else if (reply_bad_frame_d) begin
				st = ST_BAD_FRAME;
			end else if (!crc_ok) begin
				st = ST_BAD_CRC;
			end else begin
				st  = ST_OK;
				val = reply_value_d;
			end
		end

		if (fin_write) begin
			st = (rx_count_d == WRITE_FRAME_LEN && !echo_mismatch_d) ? ST_OK : ST_BAD_ECHO;
			write_count_d = write_count_q + 32'd1;
			if (st != ST_OK) begin
				echo_fault_count_d = echo_fault_count_q + 32'd1;
			end
		end

		if (fin_read || fin_write) begin
			phase_d                 = PH_IDLE;
			burst_ld.load           = 1'b1;
			burst_ld.burst.status   = st;
			burst_ld.burst.value    = val;
			burst_ld.burst.nrx      = rx_count_d;
			burst_ld.burst.last_idx = LAST_IDX_DONE;
			burst_ld.burst.wtot     = write_count_d;
			burst_ld.burst.eftot    = echo_fault_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_IDLE;
			rx_count_q         <= '0;
			echo_mismatch_q    <= 1'b0;
			reply_bad_frame_q  <= 1'b0;
			reply_crc_q        <= '0;
			reply_value_q      <= '0;
			saved_register_q   <= '0;
			write_count_q      <= '0;
			echo_fault_count_q <= '0;
		end else begin
			phase_q            <= phase_d;
			rx_count_q         <= rx_count_d;
			echo_mismatch_q    <= echo_mismatch_d;
			reply_bad_frame_q  <= reply_bad_frame_d;
			reply_crc_q        <= reply_crc_d;
			reply_value_q      <= reply_value_d;
			saved_register_q   <= saved_register_d;
			write_count_q      <= write_count_d;
			echo_fault_count_q <= echo_fault_count_d;
		end
	end

	always_ff @(posedge clk) begin
		sent_frame_q <= sent_frame_d;
	end

`ifndef NO_ASSERTIONS
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_READ) |-> (rx_count_q < READ_DONE_COUNT))
		else $error("read phase with count past reply end");
	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WRITE) |-> (rx_count_q < WRITE_FRAME_LEN))
		else $error("write phase with count past echo end");
	a_start_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && link_enabled && request.cmd == CMD_WRITE) |=> (phase_q == PH_WRITE))
		else $error("write start did not enter write phase");
`endif

endmodule

### src/swrl_emit.sv
// ----------------------------------------------------------------------------
// swrl_emit: result sequencer
// Holds one burst descriptor and sends its result beats one per ready cycle.
// ----------------------------------------------------------------------------
module swrl_emit
	import swrl_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  burst_load_t   burst_ld,
	output logic          slot_free,
	swrl_rsp_if.source    result
);

	logic       valid_q;
	logic [2:0] idx_q;
	burst_t     burst_q;
	logic       is_last;
	logic       out_fire;

	assign is_last   = (idx_q == burst_q.last_idx);
	assign out_fire  = valid_q && result.ready;
	assign slot_free = !valid_q || (result.ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (burst_ld.load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (out_fire) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_ld.load) begin
			burst_q <= burst_ld.burst;
		end
	end

	assign result.valid            = valid_q;
	assign result.tx_valid         = burst_q.tx;
	assign result.tx_byte          = burst_q.frame[idx_q];
	assign result.done_res         = !burst_q.tx;
	assign result.status           = burst_q.status;
	assign result.read_value       = burst_q.value;
	assign result.bytes_received   = burst_q.nrx;
	assign result.write_total      = burst_q.wtot;
	assign result.echo_fault_total = burst_q.eftot;
	assign result.last             = is_last;

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		burst_ld.load |-> slot_free)
		else $error("descriptor loaded over a pending burst");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= burst_q.last_idx))
		else $error("beat index past burst end");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !is_last && !burst_ld.load) |=>
		(valid_q && idx_q == $past(idx_q) + 3'd1))
		else $error("burst did not advance to next beat");
`endif

endmodule

### src/single_wire_register_link_master_unit.sv
// ----------------------------------------------------------------------------
// single_wire_register_link_master_unit: single-wire register link master
// Builds read/write request frames with CRC-8, checks echo and reply bytes,
// reports completion status and keeps write and echo fault counts.
//
//   channel   dir  beat
//   request   in   cmd, node_addr, reg_addr, write_value, rx_byte
//   result    out  tx byte or completion report, counts, last
//   apb       in   link_enabled register at byte address 0
//
// A command is processed in the cycle it is accepted; its results go out
// from the sequencer register starting the next cycle, one beat per cycle
// while result is ready. A read start gives 4 beats, a write start 8, a
// completion 1; the next command is taken as the last beat of the current
// burst leaves. Received bytes that finish nothing produce no beat.
// arst_n clears link state, counts and the link enable register.
// ----------------------------------------------------------------------------
module single_wire_register_link_master_unit
	import swrl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	swrl_req_if.sink              request,
	swrl_rsp_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic        link_enabled;
	logic        slot_free;
	burst_load_t burst_ld;

	swrl_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.link_enabled (link_enabled)
	);

	swrl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.slot_free    (slot_free),
		.link_enabled (link_enabled),
		.burst_ld     (burst_ld)
	);

	swrl_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst_ld  (burst_ld),
		.slot_free (slot_free),
		.result    (result)
	);

endmodule

### sim/single_wire_register_link_master_unit_test.sv
// ----------------------------------------------------------------------------
// single_wire_register_link_master_unit_test: link master testbench
// Drives read, write, received-byte and timeout commands into the master,
// mostly as well-formed echo/reply sequences with random content, plus bit
// flips, cut frames, abandoned transactions and idle noise. Each result beat
// is checked against a cycle-free model of the frame builder, echo and reply
// checker, CRC-8 and counters. The link enable register is toggled between
// phases while the block is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module single_wire_register_link_master_unit_test;
	import swrl_pkg::*;

	localparam int unsigned HOLD_CYCLES   = 150;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RUN_LIMIT     = 400000;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        done_res;
		logic [2:0]  status;
		logic [31:0] read_value;
		logic [3:0]  bytes_received;
		logic [31:0] write_total;
		logic [31:0] echo_fault_total;
		logic        last;
	} link_beat_t;

	typedef enum int {
		FLT_NONE,
		FLT_FLIP,
		FLT_CUT_TIMEOUT,
		FLT_CUT_ABANDON
	} frame_fault_t;

	class link_scoreboard;
		bit          link_on;
		phase_t      ph;
		logic [3:0]  rx_n;
		logic [7:0]  sent [8];
		bit          echo_bad;
		bit          reply_bad;
		logic [7:0]  reply_crc;
		logic [31:0] reply_val;
		logic [6:0]  saved_reg;
		logic [31:0] writes;
		logic [31:0] echo_faults;
		link_beat_t  pending_q [$];
		int          mismatches;
		int          beats_checked;
		int          status_seen [7];

		function new();
			link_on       = 1'b0;
			ph            = PH_IDLE;
			rx_n          = '0;
			echo_bad      = 1'b0;
			reply_bad     = 1'b0;
			reply_crc     = '0;
			reply_val     = '0;
			saved_reg     = '0;
			writes        = '0;
			echo_faults   = '0;
			mismatches    = 0;
			beats_checked = 0;
		endfunction

		// LSB-first CRC-8, poly 0x07
		static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
			logic [7:0] r;
			logic [7:0] d;
			r = c;
			d = b;
			for (int j = 0; j < 8; j++) begin
				if (r[7] != d[0]) begin
					r = {r[6:0], 1'b0} ^ CRC_POLY;
				end else begin
					r = {r[6:0], 1'b0};
				end
				d = d >> 1;
			end
			return r;
		endfunction

		function string show(link_beat_t b);
			return $sformatf("tx=%0b byte=%02h done=%0b st=%0d val=%08h n=%0d wr=%0d ef=%0d last=%0b",
				b.tx_valid, b.tx_byte, b.done_res, b.status, b.read_value,
				b.bytes_received, b.write_total, b.echo_fault_total, b.last);
		endfunction

		function void push_beat(logic tx, logic [7:0] data, logic done, logic [2:0] st,
		                        logic [31:0] val, logic [3:0] n, logic fin);
			link_beat_t b;
			b.tx_valid         = tx;
			b.tx_byte          = data;
			b.done_res         = done;
			b.status           = st;
			b.read_value       = val;
			b.bytes_received   = n;
			b.write_total      = writes;
			b.echo_fault_total = echo_faults;
			b.last             = fin;
			pending_q.push_back(b);
		endfunction

		function void finish_read(bit crc_ok);
			logic [2:0]  st;
			logic [31:0] val;
			val = '0;
			if (rx_n == 0) begin
				st = ST_NO_ECHO;
			end else if (rx_n < READ_FRAME_LEN || echo_bad) begin
				st = ST_BAD_ECHO;
			end else if (rx_n == READ_FRAME_LEN) begin
				st = ST_NO_REPLY;
			end else if (rx_n < READ_DONE_COUNT) begin
				st = ST_SHORT_REPLY;
			end else if (reply_bad) begin
				st = ST_BAD_FRAME;
			end else if (!crc_ok) begin
				st = ST_BAD_CRC;
			end else begin
				st  = ST_OK;
				val = reply_val;
			end
			ph = PH_IDLE;
			push_beat(1'b0, 8'h00, 1'b1, st, val, rx_n, 1'b1);
		endfunction

		function void finish_write();
			logic [2:0] st;
			st = (rx_n == WRITE_FRAME_LEN && !echo_bad) ? ST_OK : ST_BAD_ECHO;
			writes++;
			if (st != ST_OK) begin
				echo_faults++;
			end
			ph = PH_IDLE;
			push_beat(1'b0, 8'h00, 1'b1, st, 32'h0, rx_n, 1'b1);
		endfunction

		function void note_command(logic [1:0] cmd, logic [7:0] node, logic [6:0] regad,
		                           logic [31:0] wv, logic [7:0] rx);
			int unsigned len;
			int unsigned i;
			int unsigned p;
			logic [7:0]  c;
			if (cmd == CMD_READ || cmd == CMD_WRITE) begin
				if (!link_on) begin
					ph = PH_IDLE;
					push_beat(1'b0, 8'h00, 1'b1, ST_NO_ECHO, 32'h0, 4'd0, 1'b1);
					return;
				end
				sent[0] = SYNC_BYTE;
				sent[1] = node;
				if (cmd == CMD_READ) begin
					sent[2] = {1'b0, regad};
					len = 32'(READ_FRAME_LEN);
				end else begin
					sent[2] = {1'b0, regad} | WRITE_FLAG;
					{sent[3], sent[4], sent[5], sent[6]} = wv;
					len = 32'(WRITE_FRAME_LEN);
				end
				c = 8'h00;
				for (i = 0; i + 1 < len; i++) begin
					c = crc_step(c, sent[i]);
				end
				sent[len - 1] = c;
				ph        = (cmd == CMD_READ) ? PH_READ : PH_WRITE;
				rx_n      = '0;
				echo_bad  = 1'b0;
				reply_bad = 1'b0;
				reply_crc = '0;
				reply_val = '0;
				saved_reg = regad;
				for (i = 0; i < len; i++) begin
					push_beat(1'b1, sent[i], 1'b0, ST_OK, 32'h0, 4'd0, (i + 1 == len));
				end
				return;
			end
			if (ph == PH_IDLE) begin
				return;
			end
			if (cmd == CMD_TIMEOUT) begin
				if (ph == PH_READ) begin
					finish_read(1'b0);
				end else begin
					finish_write();
				end
				return;
			end
			i = 32'(rx_n);
			if (ph == PH_WRITE) begin
				if (i < WRITE_FRAME_LEN && rx != sent[i]) begin
					echo_bad = 1'b1;
				end
				rx_n = 4'(i + 1);
				if (rx_n >= WRITE_FRAME_LEN) begin
					finish_write();
				end
				return;
			end
			if (i < READ_FRAME_LEN) begin
				if (rx != sent[i]) begin
					echo_bad = 1'b1;
				end
			end else begin
				p = i - 32'(READ_FRAME_LEN);
				case (p)
					0: if (rx != SYNC_BYTE) reply_bad = 1'b1;
					1: if (rx != REPLY_NODE) reply_bad = 1'b1;
					2: if (rx != {1'b0, saved_reg}) reply_bad = 1'b1;
					default: ;
				endcase
				if (p >= 3 && p <= 6) begin
					reply_val = {reply_val[23:0], rx};
				end
				if (p <= 6) begin
					reply_crc = crc_step(reply_crc, rx);
				end else begin
					rx_n = READ_DONE_COUNT;
					finish_read(rx == reply_crc);
					return;
				end
			end
			rx_n = 4'(i + 1);
			if (rx_n >= READ_DONE_COUNT) begin
				finish_read(1'b0);
			end
		endfunction

		function void check_beat(link_beat_t got);
			link_beat_t want;
			beats_checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: %s", show(got));
				end
				return;
			end
			want = pending_q.pop_front();
			if (want.done_res) begin
				status_seen[want.status]++;
			end
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result beat %0d mismatch", beats_checked);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	swrl_req_if req_ch ();
	swrl_rsp_if rsp_ch ();

	link_scoreboard board = new();

	bit          hold_request;
	int unsigned burst_left;
	int unsigned items_sent;

	single_wire_register_link_master_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			board.note_command(req_ch.cmd, req_ch.node_addr, req_ch.reg_addr,
				req_ch.write_value, req_ch.rx_byte);
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			board.check_beat({rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.done_res,
				rsp_ch.status, rsp_ch.read_value, rsp_ch.bytes_received,
				rsp_ch.write_total, rsp_ch.echo_fault_total, rsp_ch.last});
		end
	end

	// result side: stretches of full, half, sparse or mostly-on ready, plus a long hold
	initial begin : receiver
		int unsigned stretch;
		int unsigned mode;
		int unsigned hold_left;
		stretch   = 0;
		mode      = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					mode    = $urandom_range(0, 3);
					stretch = $urandom_range(4, 48);
				end
				stretch--;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send(input logic [1:0] cmd, input logic [7:0] node, input logic [6:0] regad,
	                    input logic [31:0] wv, input logic [7:0] rx);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.node_addr   <= node;
		req_ch.reg_addr    <= regad;
		req_ch.write_value <= wv;
		req_ch.rx_byte     <= rx;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_noise();
		send(($urandom_range(0, 1) != 0) ? CMD_RX : CMD_TIMEOUT,
			8'($urandom), 7'($urandom), $urandom, 8'($urandom));
		items_sent++;
	endtask

	// start command, then the bytes seen on the wire: echo, and for reads the reply
	task automatic run_transaction(input bit is_write, input frame_fault_t fault,
	                               input logic [7:0] node, input logic [6:0] regad,
	                               input logic [31:0] wv, input logic [31:0] value);
		logic [7:0]  wire_bytes [12];
		logic [7:0]  c;
		int unsigned len;
		int unsigned total;
		int unsigned cut;
		int unsigned k;
		send(is_write ? CMD_WRITE : CMD_READ, node, regad, wv, 8'($urandom));
		items_sent++;
		wire_bytes[0] = SYNC_BYTE;
		wire_bytes[1] = node;
		wire_bytes[2] = {1'b0, regad} | (is_write ? WRITE_FLAG : 8'h00);
		if (is_write) begin
			{wire_bytes[3], wire_bytes[4], wire_bytes[5], wire_bytes[6]} = wv;
			len = 32'(WRITE_FRAME_LEN);
		end else begin
			len = 32'(READ_FRAME_LEN);
		end
		c = 8'h00;
		for (k = 0; k + 1 < len; k++) begin
			c = link_scoreboard::crc_step(c, wire_bytes[k]);
		end
		wire_bytes[len - 1] = c;
		total = len;
		if (!is_write) begin
			wire_bytes[4] = SYNC_BYTE;
			wire_bytes[5] = REPLY_NODE;
			wire_bytes[6] = {1'b0, regad};
			{wire_bytes[7], wire_bytes[8], wire_bytes[9], wire_bytes[10]} = value;
			c = 8'h00;
			for (k = 4; k < 11; k++) begin
				c = link_scoreboard::crc_step(c, wire_bytes[k]);
			end
			wire_bytes[11] = c;
			total = 32'(READ_DONE_COUNT);
		end
		if (fault == FLT_FLIP) begin
			k = $urandom_range(0, total - 1);
			wire_bytes[k] = wire_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
		end
		cut = (fault == FLT_CUT_TIMEOUT || fault == FLT_CUT_ABANDON) ?
			$urandom_range(0, total - 1) : total;
		for (k = 0; k < cut; k++) begin
			send(CMD_RX, 8'($urandom), 7'($urandom), $urandom, wire_bytes[k]);
			items_sent++;
		end
		if (fault == FLT_CUT_TIMEOUT) begin
			send(CMD_TIMEOUT, 8'($urandom), 7'($urandom), $urandom, 8'($urandom));
			items_sent++;
		end
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned  stop_at;
		int unsigned  pick;
		int unsigned  r;
		frame_fault_t fault;
		logic [7:0]   node;
		logic [6:0]   regad;
		logic [31:0]  wv;
		logic [31:0]  value;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_noise();
			end else begin
				r = $urandom_range(0, 99);
				fault = (r < 60) ? FLT_NONE : (r < 75) ? FLT_FLIP :
					(r < 90) ? FLT_CUT_TIMEOUT : FLT_CUT_ABANDON;
				node  = ($urandom_range(0, 7) == 0) ?
					(($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00) : 8'($urandom);
				regad = ($urandom_range(0, 7) == 0) ?
					(($urandom_range(0, 1) != 0) ? 7'h7F : 7'h00) : 7'($urandom);
				wv    = ($urandom_range(0, 7) == 0) ?
					(($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
				value = ($urandom_range(0, 7) == 0) ?
					(($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
				run_transaction(pick >= 65, fault, node, regad, wv, value);
			end
		end
	endtask

	task automatic run_disabled(input int unsigned n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				send_noise();
			end
			send(($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ,
				8'($urandom), 7'($urandom), $urandom, 8'($urandom));
			items_sent++;
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (board.pending_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic link_config(input bit enable);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_LINK_ENABLED, 2'b00};
		pwdata  <= {31'd0, enable};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.link_on = enable;
	endtask

	initial begin : stimulus
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= CMD_READ;
		req_ch.node_addr   <= 8'h00;
		req_ch.reg_addr    <= 7'h00;
		req_ch.write_value <= 32'h0;
		req_ch.rx_byte     <= 8'h00;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= 32'h0;
		hold_request = 1'b0;
		burst_left   = 0;
		items_sent   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// link off after reset: starts end at once, stray bytes are dropped
		send(CMD_READ, 8'h00, 7'h00, 32'h0, 8'h00);
		send(CMD_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
		send(CMD_RX, 8'hA5, 7'h2A, 32'h5A5A_5A5A, 8'hFF);
		send(CMD_TIMEOUT, 8'h5A, 7'h55, 32'hA5A5_A5A5, 8'h00);
		items_sent += 4;
		settle();
		link_config(1'b1);

		run_transaction(1'b1, FLT_NONE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 32'h0);
		send(CMD_READ, 8'h00, 7'h00, 32'h0, 8'h00);
		send(CMD_TIMEOUT, 8'h00, 7'h00, 32'h0, 8'h00);
		send(CMD_WRITE, 8'h00, 7'h00, 32'h0, 8'h00);
		send(CMD_TIMEOUT, 8'h00, 7'h00, 32'h0, 8'h00);
		// restart: write dropped, read then times out
		send(CMD_WRITE, 8'h12, 7'h34, 32'h1234_5678, 8'h00);
		send(CMD_READ, 8'h34, 7'h12, 32'h0, 8'h00);
		send(CMD_TIMEOUT, 8'h00, 7'h00, 32'h0, 8'h00);
		items_sent += 7;
		settle();

		run_random(120);
		hold_request = 1'b1;
		run_random(40);
		settle();
		run_random(60);
		settle();
		link_config(1'b0);
		run_disabled(16);
		settle();
		link_config(1'b1);
		run_random(90);
		settle();

		$display("Covered %0d commands and %0d result beats, link on and off.",
			items_sent, board.beats_checked);
		$display("Completions: ok %0d, no echo %0d, bad echo %0d, no reply %0d, short %0d, bad frame %0d, bad crc %0d",
			board.status_seen[ST_OK], board.status_seen[ST_NO_ECHO],
			board.status_seen[ST_BAD_ECHO], board.status_seen[ST_NO_REPLY],
			board.status_seen[ST_SHORT_REPLY], board.status_seen[ST_BAD_FRAME],
			board.status_seen[ST_BAD_CRC]);
		if (board.mismatches == 0 && board.pending_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
